### design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// shared types, constants and helpers of the integer to ascii formatter
// ----------------------------------------------------------------------------
package ita_pkg;

	localparam int VALUE_W   = 64;
	localparam int CMD_W     = 3;
	localparam int SIZE_W    = 2;
	localparam int WIDTH_W   = 7;
	localparam int CHAR_W    = 8;
	localparam int MAX_WIDTH = 64;

	localparam int SLOT_W    = 4;
	localparam int NUM_SLOTS = 22;
	localparam int SLOTS_W   = NUM_SLOTS * SLOT_W;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int VAL_W     = VALUE_W + 2;
	localparam int OCT_BITS  = 3;

	localparam int DEC_STEPS = VALUE_W;
	localparam int OCT_STEPS = (VALUE_W + OCT_BITS - 1) / OCT_BITS;
	localparam int HEX_STEPS = VALUE_W / SLOT_W;
	localparam int STEP_W    = $clog2(DEC_STEPS + 1);

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [SLOT_W-1:0]  digit_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_DEC  = 3'd0,
		CMD_OCT  = 3'd1,
		CMD_HEXL = 3'd2,
		CMD_HEXU = 3'd3,
		CMD_PTR  = 3'd4
	} cmd_t;

	typedef enum logic [SIZE_W-1:0] {
		SZ_BYTE   = 2'd0,
		SZ_HALF   = 2'd1,
		SZ_WORD   = 2'd2,
		SZ_DOUBLE = 2'd3
	} size_t;

	localparam char_t CH_ZERO    = 8'h30;
	localparam char_t CH_SPACE   = 8'h20;
	localparam char_t CH_MINUS   = 8'h2d;
	localparam char_t CH_LOWER_X = 8'h78;
	localparam char_t CH_LOWER_A = 8'h61;
	localparam char_t CH_UPPER_A = 8'h41;

	typedef struct packed {
		width_t width;
		logic   pad_zero;
		logic   pad_right;
	} job_t;

	typedef struct packed {
		logic valid;
		cnt_t ndig;
		logic neg;
		logic ptr;
		logic caps;
	} conv_res_t;

	function automatic char_t digit_char(input digit_t d, input logic caps);
		char_t base_c;
		base_c = caps ? CH_UPPER_A : CH_LOWER_A;
		if (d < digit_t'(10))
			digit_char = CH_ZERO + char_t'(d);
		else
			digit_char = base_c + char_t'(d) - char_t'(10);
	endfunction

endpackage

### design/ita_digits.sv
// ----------------------------------------------------------------------------
// ita_digits
// bit-serial digit generator: double dabble for decimal, nibble or 3-bit
// shifting for hex and octal, leading zero strip, then a digit stack popped
// most significant digit first
// ----------------------------------------------------------------------------
module ita_digits (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ita_pkg::VALUE_W-1:0]    value,
	input  logic [ita_pkg::CMD_W-1:0]      cmd,
	input  logic [ita_pkg::SIZE_W-1:0]     size,
	input  logic                           pop,
	output logic                           busy,
	output ita_pkg::conv_res_t             res,
	output ita_pkg::digit_t                top_digit
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_STRIP, ST_READY} state_t;

	state_t                        state_q;
	logic [ita_pkg::VAL_W-1:0]     val_q;
	logic [ita_pkg::SLOTS_W-1:0]   slots_q;
	ita_pkg::step_t                step_q;
	ita_pkg::cnt_t                 ndig_q;
	logic                          dec_q;
	logic                          oct_q;
	logic                          neg_q;
	logic                          ptr_q;
	logic                          caps_q;

	logic [ita_pkg::VALUE_W-1:0]   zx;
	logic [ita_pkg::VALUE_W-1:0]   sx;
	logic [ita_pkg::VALUE_W-1:0]   ext;
	logic [ita_pkg::VALUE_W-1:0]   mag;
	logic                          neg;
	logic [ita_pkg::SLOTS_W-1:0]   adj;
	ita_pkg::digit_t               s;

	always_comb begin
		unique case (ita_pkg::size_t'(size))
			ita_pkg::SZ_BYTE: begin
				zx = {56'b0, value[7:0]};
				sx = {{56{value[7]}}, value[7:0]};
			end
			ita_pkg::SZ_HALF: begin
				zx = {48'b0, value[15:0]};
				sx = {{48{value[15]}}, value[15:0]};
			end
			ita_pkg::SZ_WORD: begin
				zx = {32'b0, value[31:0]};
				sx = {{32{value[31]}}, value[31:0]};
			end
			ita_pkg::SZ_DOUBLE: begin
				zx = value;
				sx = value;
			end
		endcase
		if (cmd == ita_pkg::CMD_PTR)
			ext = value;
		else if (cmd == ita_pkg::CMD_DEC)
			ext = sx;
		else
			ext = zx;
		neg = (cmd == ita_pkg::CMD_DEC) && ext[ita_pkg::VALUE_W-1];
		mag = neg ? (~ext + 64'd1) : ext;
	end

	// add-3 correction on every bcd digit
	always_comb begin
		s   = '0;
		adj = '0;
		for (int i = 0; i < ita_pkg::NUM_SLOTS; i++) begin
			s = slots_q[i*ita_pkg::SLOT_W +: ita_pkg::SLOT_W];
			adj[i*ita_pkg::SLOT_W +: ita_pkg::SLOT_W] =
				(s >= ita_pkg::digit_t'(5)) ? s + ita_pkg::digit_t'(3) : s;
		end
	end

	assign top_digit = slots_q[ita_pkg::SLOTS_W-1 -: ita_pkg::SLOT_W];
	assign busy      = (state_q != ST_IDLE);
	assign res.valid = (state_q == ST_READY);
	assign res.ndig  = ndig_q;
	assign res.neg   = neg_q;
	assign res.ptr   = ptr_q;
	assign res.caps  = caps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			val_q   <= '0;
			slots_q <= '0;
			step_q  <= '0;
			ndig_q  <= '0;
			dec_q   <= 1'b0;
			oct_q   <= 1'b0;
			neg_q   <= 1'b0;
			ptr_q   <= 1'b0;
			caps_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						dec_q   <= (cmd == ita_pkg::CMD_DEC);
						oct_q   <= (cmd == ita_pkg::CMD_OCT);
						neg_q   <= neg;
						ptr_q   <= (cmd == ita_pkg::CMD_PTR);
						caps_q  <= (cmd == ita_pkg::CMD_HEXU);
						slots_q <= '0;
						if (cmd == ita_pkg::CMD_OCT) begin
							val_q  <= {2'b0, mag};
							step_q <= ita_pkg::step_t'(ita_pkg::OCT_STEPS - 1);
						end else if (cmd == ita_pkg::CMD_DEC) begin
							val_q  <= {mag, 2'b0};
							step_q <= ita_pkg::step_t'(ita_pkg::DEC_STEPS - 1);
						end else begin
							val_q  <= {mag, 2'b0};
							step_q <= ita_pkg::step_t'(ita_pkg::HEX_STEPS - 1);
						end
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dec_q) begin
						slots_q <= {adj[ita_pkg::SLOTS_W-2:0], val_q[ita_pkg::VAL_W-1]};
						val_q   <= {val_q[ita_pkg::VAL_W-2:0], 1'b0};
					end else if (oct_q) begin
						slots_q <= {slots_q[ita_pkg::SLOTS_W-ita_pkg::SLOT_W-1:0], 1'b0,
							val_q[ita_pkg::VAL_W-1 -: ita_pkg::OCT_BITS]};
						val_q   <= {val_q[ita_pkg::VAL_W-ita_pkg::OCT_BITS-1:0], 3'b0};
					end else begin
						slots_q <= {slots_q[ita_pkg::SLOTS_W-ita_pkg::SLOT_W-1:0],
							val_q[ita_pkg::VAL_W-1 -: ita_pkg::SLOT_W]};
						val_q   <= {val_q[ita_pkg::VAL_W-ita_pkg::SLOT_W-1:0], 4'b0};
					end
					if (step_q == '0) begin
						ndig_q  <= ita_pkg::cnt_t'(ita_pkg::NUM_SLOTS);
						state_q <= ST_STRIP;
					end else begin
						step_q <= step_q - ita_pkg::step_t'(1);
					end
				end
				ST_STRIP: begin
					if (top_digit == '0 && ndig_q != ita_pkg::cnt_t'(1)) begin
						slots_q <= {slots_q[ita_pkg::SLOTS_W-ita_pkg::SLOT_W-1:0],
							ita_pkg::digit_t'(0)};
						ndig_q  <= ndig_q - ita_pkg::cnt_t'(1);
					end else begin
						state_q <= ST_READY;
					end
				end
				ST_READY: begin
					if (pop) begin
						slots_q <= {slots_q[ita_pkg::SLOTS_W-ita_pkg::SLOT_W-1:0],
							ita_pkg::digit_t'(0)};
						ndig_q  <= ndig_q - ita_pkg::cnt_t'(1);
						if (ndig_q == ita_pkg::cnt_t'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("conversion started while busy");

	a_ready_ndig: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READY |-> ndig_q != '0)
		else $error("digit stack empty while ready");

	a_pop_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_READY)
		else $error("digit popped outside ready");

endmodule

### design/ita_emit.sv
// ----------------------------------------------------------------------------
// ita_emit
// character sequencer: left pad, prefix, sign, digits, right pad, one
// character per transaction into an output register
// ----------------------------------------------------------------------------
module ita_emit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ita_pkg::job_t           job,
	input  ita_pkg::conv_res_t      conv,
	input  ita_pkg::digit_t         top_digit,
	output logic                    pop,
	output logic                    idle,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output ita_pkg::char_t          m_tdata,
	output logic                    m_tlast
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_PADL, PH_PFX0, PH_PFXX, PH_MINUS, PH_DIG, PH_PADR
	} phase_t;

	phase_t             phase_q;
	ita_pkg::width_t    padcnt_q;
	ita_pkg::cnt_t      digcnt_q;
	logic               neg_q;
	logic               ptr_q;
	logic               caps_q;
	logic               pad_zero_q;
	logic               pad_right_q;
	logic               tvalid_q;
	ita_pkg::char_t     tdata_q;
	logic               tlast_q;

	ita_pkg::width_t    w_sat;
	ita_pkg::width_t    tlen;
	ita_pkg::width_t    pad;
	ita_pkg::char_t     pad_char;
	phase_t             first;
	logic               load;

	always_comb begin
		w_sat = (job.width > ita_pkg::width_t'(ita_pkg::MAX_WIDTH)) ?
			ita_pkg::width_t'(ita_pkg::MAX_WIDTH) : job.width;
		tlen  = ita_pkg::width_t'(conv.ndig) + ita_pkg::width_t'(conv.neg) +
			(conv.ptr ? ita_pkg::width_t'(2) : ita_pkg::width_t'(0));
		pad   = (w_sat > tlen) ? w_sat - tlen : '0;
		if (!job.pad_right && pad != '0)
			first = PH_PADL;
		else if (conv.ptr)
			first = PH_PFX0;
		else if (conv.neg)
			first = PH_MINUS;
		else
			first = PH_DIG;
		pad_char = pad_zero_q ? ita_pkg::CH_ZERO : ita_pkg::CH_SPACE;
		load     = (phase_q != PH_IDLE) && (!tvalid_q || m_tready);
	end

	assign pop      = load && (phase_q == PH_DIG);
	assign idle     = (phase_q == PH_IDLE);
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			padcnt_q    <= '0;
			digcnt_q    <= '0;
			neg_q       <= 1'b0;
			ptr_q       <= 1'b0;
			caps_q      <= 1'b0;
			pad_zero_q  <= 1'b0;
			pad_right_q <= 1'b0;
			tvalid_q    <= 1'b0;
			tdata_q     <= '0;
			tlast_q     <= 1'b0;
		end else begin
			if (load)
				tvalid_q <= 1'b1;
			else if (m_tready)
				tvalid_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (conv.valid) begin
						padcnt_q    <= pad;
						digcnt_q    <= conv.ndig;
						neg_q       <= conv.neg;
						ptr_q       <= conv.ptr;
						caps_q      <= conv.caps;
						pad_zero_q  <= job.pad_zero;
						pad_right_q <= job.pad_right;
						phase_q     <= first;
					end
				end
				PH_PADL: begin
					if (load) begin
						tdata_q  <= pad_char;
						tlast_q  <= 1'b0;
						padcnt_q <= padcnt_q - ita_pkg::width_t'(1);
						if (padcnt_q == ita_pkg::width_t'(1)) begin
							if (ptr_q)
								phase_q <= PH_PFX0;
							else if (neg_q)
								phase_q <= PH_MINUS;
							else
								phase_q <= PH_DIG;
						end
					end
				end
				PH_PFX0: begin
					if (load) begin
						tdata_q <= ita_pkg::CH_ZERO;
						tlast_q <= 1'b0;
						phase_q <= PH_PFXX;
					end
				end
				PH_PFXX: begin
					if (load) begin
						tdata_q <= ita_pkg::CH_LOWER_X;
						tlast_q <= 1'b0;
						phase_q <= PH_DIG;
					end
				end
				PH_MINUS: begin
					if (load) begin
						tdata_q <= ita_pkg::CH_MINUS;
						tlast_q <= 1'b0;
						phase_q <= PH_DIG;
					end
				end
				PH_DIG: begin
					if (load) begin
						tdata_q  <= ita_pkg::digit_char(top_digit, caps_q);
						tlast_q  <= (digcnt_q == ita_pkg::cnt_t'(1)) &&
							!(pad_right_q && padcnt_q != '0);
						digcnt_q <= digcnt_q - ita_pkg::cnt_t'(1);
						if (digcnt_q == ita_pkg::cnt_t'(1)) begin
							if (pad_right_q && padcnt_q != '0) begin
								phase_q <= PH_PADR;
							end else begin
								phase_q <= PH_IDLE;
							end
						end
					end
				end
				PH_PADR: begin
					if (load) begin
						tdata_q  <= pad_char;
						tlast_q  <= (padcnt_q == ita_pkg::width_t'(1));
						padcnt_q <= padcnt_q - ita_pkg::width_t'(1);
						if (padcnt_q == ita_pkg::width_t'(1)) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	a_dig_conv: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIG |-> conv.valid)
		else $error("digit phase without digits ready");

	a_padl_side: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PADL |-> !pad_right_q && padcnt_q != '0)
		else $error("left padding on a right padded item");

	a_padr_side: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PADR |-> pad_right_q && padcnt_q != '0)
		else $error("right padding on a left padded item");

endmodule

### design/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// printf style integer conversion of one 64-bit value into a character stream
// ----------------------------------------------------------------------------
// conversion: 16 hex, 22 octal or 64 decimal bit-serial steps, a leading zero
//   strip, then the first character passes through the emitter's phase
//   register into the output register
// throughput: one character per cycle unless m_tready stalls, max(min(width, 64),
//   text length) characters; next item taken once the last is in the output register
// reset: arst_n clears all control state at once, no clearing pass
module integer_to_ascii_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // value[63:0], field_width[70:64], pad_with_zero[71],
	                               // pad_on_right[72], zeros above
	input  logic [4:0]  s_tuser,   // command[2:0], operand_size[4:3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // char_out[7:0]
	output logic        m_tlast
);

	ita_pkg::job_t       job_q;
	ita_pkg::conv_res_t  conv;
	ita_pkg::digit_t     top_digit;
	logic                conv_busy;
	logic                emit_idle;
	logic                pop;
	logic                accept;
	logic                start;

	assign s_tready = !conv_busy && emit_idle;
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (s_tuser[2:0] <= ita_pkg::CMD_PTR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0;
		end else if (accept) begin
			job_q.width     <= s_tdata[70:64];
			job_q.pad_zero  <= s_tdata[71];
			job_q.pad_right <= s_tdata[72];
		end
	end

	ita_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (s_tdata[63:0]),
		.cmd       (s_tuser[2:0]),
		.size      (s_tuser[4:3]),
		.pop       (pop),
		.busy      (conv_busy),
		.res       (conv),
		.top_digit (top_digit)
	);

	ita_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_q),
		.conv      (conv),
		.top_digit (top_digit),
		.pop       (pop),
		.idle      (emit_idle),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives formatting requests into integer_to_ascii_formatter_top and checks
// every character against typed text or a behavioral formatter: directed
// corner cases first, then random ones under several stall and idle patterns
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ita_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int TEXT_BYTES     = 24;
	localparam int NUM_DIRECTED   = 25;
	localparam int RANDOM_PER_PH  = 30;
	localparam int TAIL_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	typedef struct packed {
		logic [VALUE_W-1:0]      value;
		logic [CMD_W-1:0]        cmd;
		logic [SIZE_W-1:0]       size;
		width_t                  width;
		logic                    zpad;
		logic                    rpad;
		logic                    typed;
		logic [8*TEXT_BYTES-1:0] text;
	} fmt_req_t;

	typedef struct packed {
		char_t ch;
		logic  last;
	} out_char_t;

	localparam fmt_req_t DIRECTED [NUM_DIRECTED] = '{
		'{64'h0, CMD_DEC, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1, "0"},
		'{64'h0, CMD_OCT, SZ_BYTE, 7'd4, 1'b1, 1'b0, 1'b1, "0000"},
		'{64'h0, CMD_PTR, SZ_BYTE, 7'd6, 1'b0, 1'b1, 1'b1, "0x0   "},
		'{64'hfb, CMD_DEC, SZ_BYTE, 7'd5, 1'b1, 1'b0, 1'b1, "000-5"},
		'{64'hfb, CMD_DEC, SZ_BYTE, 7'd5, 1'b0, 1'b0, 1'b1, "   -5"},
		'{64'hfb, CMD_DEC, SZ_BYTE, 7'd5, 1'b1, 1'b1, 1'b1, "-5000"},
		'{64'hff, CMD_DEC, SZ_BYTE, 7'd0, 1'b0, 1'b0, 1'b1, "-1"},
		'{64'h7f, CMD_DEC, SZ_BYTE, 7'd0, 1'b0, 1'b0, 1'b1, "127"},
		'{64'h1234_5680, CMD_DEC, SZ_BYTE, 7'd0, 1'b0, 1'b0, 1'b1, "-128"},
		'{64'h8000, CMD_DEC, SZ_HALF, 7'd0, 1'b0, 1'b0, 1'b1, "-32768"},
		'{64'h8000_0000, CMD_DEC, SZ_WORD, 7'd0, 1'b0, 1'b0, 1'b1, "-2147483648"},
		'{64'h8000_0000_0000_0000, CMD_DEC, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1,
			"-9223372036854775808"},
		'{'1, CMD_DEC, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1, "-1"},
		'{'1, CMD_OCT, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1, "1777777777777777777777"},
		'{'1, CMD_OCT, SZ_BYTE, 7'd0, 1'b0, 1'b0, 1'b1, "377"},
		'{64'hdeadbeef_cafef00d, CMD_HEXL, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1,
			"deadbeefcafef00d"},
		'{64'hdeadbeef_cafef00d, CMD_HEXU, SZ_DOUBLE, 7'd0, 1'b0, 1'b0, 1'b1,
			"DEADBEEFCAFEF00D"},
		'{64'hdeadbeef_cafef00d, CMD_HEXU, SZ_WORD, 7'd0, 1'b0, 1'b0, 1'b1, "CAFEF00D"},
		'{64'hdeadbeef_cafef00d, CMD_PTR, SZ_BYTE, 7'd0, 1'b0, 1'b0, 1'b1,
			"0xdeadbeefcafef00d"},
		'{'1, CMD_HEXL, SZ_HALF, 7'd127, 1'b0, 1'b0, 1'b0, '0},
		'{64'h1, CMD_DEC, SZ_DOUBLE, 7'd64, 1'b1, 1'b1, 1'b0, '0},
		'{64'd123, CMD_DEC, SZ_DOUBLE, 7'd65, 1'b0, 1'b0, 1'b0, '0},
		'{64'h5, CMD_RSVD5, SZ_BYTE, 7'd3, 1'b0, 1'b0, 1'b1, ""},
		'{'1, CMD_RSVD6, SZ_DOUBLE, 7'd10, 1'b1, 1'b1, 1'b1, ""},
		'{64'h0, CMD_RSVD7, SZ_WORD, 7'd127, 1'b1, 1'b0, 1'b1, ""}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [4:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	out_char_t pending_chars[$];
	out_char_t want;
	fmt_req_t  pending_req = '0;
	string     line_text;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        fail_count = 0;
	int        chars_checked = 0;
	int        quiet_cycles = 0;
	int        cmd_seen [8] = '{default: 0};

	integer_to_ascii_formatter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic string render_expected(input logic [VALUE_W-1:0] raw,
			input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
			input width_t width, input logic zpad, input logic rpad);
		logic [VALUE_W-1:0] mag, mask, radix, d;
		int                 bits, cap, nd, w;
		logic               neg, ptr, caps;
		char_t              digits [VALUE_W];
		char_t              fill;
		string              body, line;
		if (cmd > CMD_PTR)
			return "";
		mag = raw;
		neg = 1'b0;
		ptr = (cmd == CMD_PTR);
		caps = (cmd == CMD_HEXU);
		radix = 64'd16;
		nd = 0;
		if (!ptr) begin
			bits = 8 << size;
			if (bits < VALUE_W) begin
				mask = (64'd1 << bits) - 64'd1;
				mag &= mask;
				if (cmd == CMD_DEC && mag[bits-1])
					mag |= ~mask;
			end
			if (cmd == CMD_DEC) begin
				radix = 64'd10;
				if (mag[VALUE_W-1]) begin
					neg = 1'b1;
					mag = 64'd0 - mag;
				end
			end else if (cmd == CMD_OCT) begin
				radix = 64'd8;
			end
		end
		// room for 31 characters including sign and prefix
		cap = 31 - (neg ? 1 : 0) - (ptr ? 2 : 0);
		while (mag != 0) begin
			d = mag % radix;
			mag = mag / radix;
			if (nd < cap) begin
				if (d < 64'd10)
					digits[nd] = CH_ZERO + char_t'(d);
				else
					digits[nd] = (caps ? CH_UPPER_A : CH_LOWER_A) + char_t'(d) - 8'd10;
				nd++;
			end
		end
		if (nd == 0) begin
			digits[0] = CH_ZERO;
			nd = 1;
		end
		body = ptr ? $sformatf("%c%c", CH_ZERO, CH_LOWER_X) : "";
		if (neg)
			body = $sformatf("%s%c", body, CH_MINUS);
		for (int i = nd - 1; i >= 0; i--)
			body = $sformatf("%s%c", body, digits[i]);
		w = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
		fill = zpad ? CH_ZERO : CH_SPACE;
		line = body;
		for (int i = body.len(); i < w; i++)
			line = rpad ? $sformatf("%s%c", line, fill) : $sformatf("%c%s", fill, line);
		return line;
	endfunction

	function automatic fmt_req_t random_request();
		fmt_req_t           r;
		logic [VALUE_W-1:0] noise;
		int                 bits;
		r = '0;
		noise = {$urandom, $urandom};
		r.cmd = ($urandom_range(11) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		r.size = 2'($urandom_range(3));
		r.zpad = 1'($urandom_range(1));
		r.rpad = 1'($urandom_range(1));
		case ($urandom_range(9))
			7, 8: r.width = 7'($urandom_range(25, 64));
			9: r.width = 7'($urandom_range(65, 127));
			default: r.width = 7'($urandom_range(24));
		endcase
		bits = 8 << r.size;
		case ($urandom_range(4))
			0: r.value = noise;
			1: r.value = 64'($urandom_range(20));
			2: begin
				// around the sign boundary of the operand, junk above it
				r.value = (64'd1 << (bits - 1)) - 64'd2 + 64'($urandom_range(4));
				if (bits < VALUE_W)
					r.value |= noise << bits;
			end
			3: r.value = ~64'($urandom_range(20));
			default: r.value = noise >> $urandom_range(63);
		endcase
		return r;
	endfunction

	task automatic send_request(input fmt_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		pending_req = r;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, r.rpad, r.zpad, r.width, r.value};
		s_tuser <= {r.size, r.cmd};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				cmd_seen[s_tuser[2:0]]++;
				if (pending_req.typed) begin
					line_text = "";
					for (int i = TEXT_BYTES - 1; i >= 0; i--)
						if (pending_req.text[8*i +: 8] != 8'd0)
							line_text = $sformatf("%s%c", line_text, pending_req.text[8*i +: 8]);
				end else begin
					line_text = render_expected(s_tdata[63:0], s_tuser[2:0], s_tuser[4:3],
						s_tdata[70:64], s_tdata[71], s_tdata[72]);
				end
				for (int i = 0; i < line_text.len(); i++)
					pending_chars.push_back('{line_text[i], i == line_text.len() - 1});
			end
			if (m_tvalid && m_tready) begin
				chars_checked++;
				if (pending_chars.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected character 0x%02h last %0b", m_tdata, m_tlast);
				end else begin
					want = pending_chars.pop_front();
					if (m_tdata !== want.ch || m_tlast !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected 0x%02h '%c' last %0b, got 0x%02h last %0b",
								want.ch, want.ch, want.last, m_tdata, m_tlast);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("integer_to_ascii_formatter_top test failed");
		$finish;
	end

	initial begin
		fmt_req_t req;
		int       sent;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_request(DIRECTED[i]);

		// no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 25 : 0;
			recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 25 : 0;
			sent = 0;
			while (sent < RANDOM_PER_PH) begin
				req = random_request();
				send_request(req);
				if (req.cmd <= CMD_PTR)
					sent++;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d decimal, %0d octal, %0d hex, %0d HEX, %0d pointer, %0d ignored",
			cmd_seen[CMD_DEC], cmd_seen[CMD_OCT], cmd_seen[CMD_HEXL], cmd_seen[CMD_HEXU],
			cmd_seen[CMD_PTR], cmd_seen[CMD_RSVD5] + cmd_seen[CMD_RSVD6] + cmd_seen[CMD_RSVD7]);
		$display("%0d characters checked across four stall patterns, %0d mismatches",
			chars_checked, fail_count);
		if (fail_count == 0 && pending_chars.size() == 0)
			$display("integer_to_ascii_formatter_top test passed");
		else
			$display("integer_to_ascii_formatter_top test failed");
		$finish;
	end

endmodule

### integer_to_ascii_formatter_top.f
design/ita_pkg.sv
design/ita_digits.sv
design/ita_emit.sv
design/integer_to_ascii_formatter_top.sv
sim/testbench.sv
